// File: hw/rtl/tmcr_pkg.sv
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types, field layouts, codes and the 16-color palette of the text
// cell renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcr_pkg;

   // default screen geometry in cells
   localparam int TEXT_COLS_DEF = 80;
   localparam int TEXT_ROWS_DEF = 25;

   // field widths
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CUR_W    = 8;
   localparam int GIDX_W   = 8;
   localparam int GLYPH_W  = 64;
   localparam int PAIR_W   = CHAR_W + ATTR_W;
   localparam int PIX_X_W  = 10;
   localparam int PIX_Y_W  = 8;
   localparam int COLOR_W  = 32;
   localparam int GLYPH_DEPTH = 256;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 56;

   // opcode carried in req_tuser
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // request word, first field in the low bits
   typedef struct packed {
      logic [1:0]         pad;
      logic [GLYPH_W-1:0] glyph_bits;
      logic [GIDX_W-1:0]  glyph_index;
      logic [CUR_W-1:0]   cursor_row;
      logic [CUR_W-1:0]   cursor_col;
      logic               cursor_shown;
      logic               force_redraw;
      logic [ATTR_W-1:0]  attr_byte;
      logic [CHAR_W-1:0]  char_code;
      logic [ROW_W-1:0]   cell_row;
      logic [COL_W-1:0]   cell_col;
   } req_word_type;

   // response word, first field in the low bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [COLOR_W-1:0] pixel_color;
      logic [PIX_Y_W-1:0] pixel_y;
      logic [PIX_X_W-1:0] pixel_x;
   } rsp_word_type;

   // one entry of the shown-cell store
   typedef struct packed {
      logic              valid;
      logic [PAIR_W-1:0] pair;
   } shown_entry_type;

   // cell handed to the pixel generator
   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic [GLYPH_W-1:0] glyph;
   } cell_job_type;

   // 16-color text palette, ARGB8888
   function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] idx);
      logic [COLOR_W-1:0] c;
      unique case (idx)
         4'h0: c = 32'hFF000000;
         4'h1: c = 32'hFF0000AA;
         4'h2: c = 32'hFF00AA00;
         4'h3: c = 32'hFF00AAAA;
         4'h4: c = 32'hFFAA0000;
         4'h5: c = 32'hFFAA00AA;
         4'h6: c = 32'hFFAA5500;
         4'h7: c = 32'hFFAAAAAA;
         4'h8: c = 32'hFF555555;
         4'h9: c = 32'hFF5555FF;
         4'hA: c = 32'hFF55FF55;
         4'hB: c = 32'hFF55FFFF;
         4'hC: c = 32'hFFFF5555;
         4'hD: c = 32'hFFFF55FF;
         4'hE: c = 32'hFFFFFF55;
         4'hF: c = 32'hFFFFFFFF;
         default: c = 32'hFF000000;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tmcr_glyph_store.sv
// ----------------------------------------------------------------------------
// tmcr_glyph_store
// 256 x 64 glyph memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcr_glyph_store (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [tmcr_pkg::GIDX_W-1:0]            wr_addr,
   input  logic [tmcr_pkg::GLYPH_W-1:0]           wr_data,
   input  logic                                   rd_en,
   input  logic [tmcr_pkg::CHAR_W-1:0]            rd_addr,
   output logic [tmcr_pkg::GLYPH_W-1:0]           rd_data
);
   import tmcr_pkg::*;

   logic [GLYPH_W-1:0] mem [GLYPH_DEPTH];
   logic [GLYPH_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tmcr_shown_store.sv
// ----------------------------------------------------------------------------
// tmcr_shown_store
// Memory of the last drawn char/attr pair per cell, with a clearing sweep
// after reset that marks every entry invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcr_shown_store #(
   parameter int CELL_COUNT = tmcr_pkg::TEXT_COLS_DEF * tmcr_pkg::TEXT_ROWS_DEF,
   parameter int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CELL_W-1:0]         wr_addr,
   input  tmcr_pkg::shown_entry_type wr_data,
   input  logic                      rd_en,
   input  logic [CELL_W-1:0]         rd_addr,
   output tmcr_pkg::shown_entry_type rd_data,
   output logic                      clear_busy
);
   import tmcr_pkg::*;

   shown_entry_type mem [CELL_COUNT];
   shown_entry_type rd_data_ff;
   logic [CELL_W-1:0] clear_idx_ff;
   logic              clear_busy_ff;
   logic              clear_last;

   assign clear_last = (clear_idx_ff == CELL_W'(CELL_COUNT - 1));

   // clearing sweep, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
         if (clear_last) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // write port, sweep has priority
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tmcr_pixel_gen.sv
// ----------------------------------------------------------------------------
// tmcr_pixel_gen
// Walks one 8x8 cell and sends its 64 pixels, row by row, left to right.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcr_pixel_gen (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_en,
   input  tmcr_pkg::cell_job_type               load_job,
   output logic                                 free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tmcr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import tmcr_pkg::*;

   cell_job_type job_ff;
   logic [5:0]   count_ff;
   logic         busy_ff;
   logic         fire;
   logic         last;
   logic [2:0]   gx;
   logic [2:0]   gy;
   logic         bit_on;
   rsp_word_type word;

   assign gx     = count_ff[2:0];
   assign gy     = count_ff[5:3];
   assign last   = (count_ff == 6'd63);
   assign fire   = busy_ff && rsp_tready;
   assign free   = !busy_ff || (rsp_tready && last);

   // byte gy is pixel row gy, MSB leftmost
   assign bit_on = job_ff.glyph[{gy, ~gx}];

   // pixel counter and job hold
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (load_en) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_ff + 1'b1;
         if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         job_ff <= load_job;
      end
   end

   // output word
   always_comb begin
      word             = '0;
      word.pixel_x     = {job_ff.col, gx};
      word.pixel_y     = {job_ff.row, gy};
      word.pixel_color = bit_on ? job_ff.fg : job_ff.bg;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = word;
   assign rsp_tlast  = last;

endmodule

`default_nettype wire

// File: hw/rtl/text_mode_cell_renderer.sv
// ----------------------------------------------------------------------------
// text_mode_cell_renderer
// Draws one text cell into 8x8 ARGB pixels, skipping cells that did not
// change since they were last drawn. Glyphs are loaded through the same port.
// ----------------------------------------------------------------------------
// Channel | Dir | Word                                         | Side bits
// req     | in  | tdata: glyph load / cell render fields       | tuser: op
// rsp     | out | tdata: pixel_x, pixel_y, pixel_color         | tlast: last pixel
//
// A drawn cell sends 64 pixels, one per cycle at the rsp port unless rsp stalls.
// Loads, skipped cells and cells off screen send no pixels and hold no later word.
// On-screen cell renders pass a read stage (shown-cell and glyph memory reads)
// and a decide stage; the next cell is decided while pixels go out.
// After reset, a clearing pass over all TEXT_COLS*TEXT_ROWS cells marks them
// invalid; req_tready stays low until it ends.
// A stalled rsp holds the pixel generator and, once a drawn cell waits, req.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_cell_renderer #(
   parameter int TEXT_COLS = tmcr_pkg::TEXT_COLS_DEF,
   parameter int TEXT_ROWS = tmcr_pkg::TEXT_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // [6:0] cell_col, [11:7] cell_row, [19:12] char_code, [27:20] attr_byte,
   // [28] force_redraw, [29] cursor_shown, [37:30] cursor_col,
   // [45:38] cursor_row, [53:46] glyph_index, [117:54] glyph_bits, zero pad
   input  logic [tmcr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,   // op
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] pixel_x, [17:10] pixel_y, [49:18] pixel_color, zero pad
   output logic [tmcr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import tmcr_pkg::*;

   localparam int CellCount = TEXT_COLS * TEXT_ROWS;
   localparam int CellW     = (CellCount > 1) ? $clog2(CellCount) : 1;

   req_word_type    req_w;
   logic            req_fire;
   logic            is_render;
   logic            in_range;
   logic            at_cursor;
   logic            a_take;
   logic [CellW-1:0] a_cell;

   // decide stage
   logic               b_valid_ff;
   logic [CellW-1:0]   b_cell_ff;
   logic [PAIR_W-1:0]  b_pair_ff;
   logic               b_cursor_ff;
   logic               b_force_ff;
   logic [COL_W-1:0]   b_col_ff;
   logic [ROW_W-1:0]   b_row_ff;
   logic               fwd_hit_ff;
   logic               fwd_hit_in;
   logic [PAIR_W-1:0]  fwd_pair_ff;

   shown_entry_type    shown_rd;
   shown_entry_type    shown_wr_data;
   logic               shown_wr;
   logic               clear_busy;
   logic [GLYPH_W-1:0] glyph_rd;

   logic               eff_valid;
   logic [PAIR_W-1:0]  eff_pair;
   logic               b_draw;
   logic               b_go;
   logic               b_free;
   logic               emit_free;
   logic               emit_load;
   cell_job_type       job;
   logic [3:0]         fg_idx;
   logic [3:0]         bg_idx;

   assign req_w     = req_word_type'(req_tdata);
   assign req_fire  = req_tvalid && req_tready;
   assign is_render = (req_tuser == OP_RENDER);
   assign in_range  = (32'(req_w.cell_col) < 32'(TEXT_COLS)) &&
                      (32'(req_w.cell_row) < 32'(TEXT_ROWS));
   assign a_cell    = CellW'(32'(req_w.cell_row) * 32'(TEXT_COLS) + 32'(req_w.cell_col));
   assign at_cursor = req_w.cursor_shown &&
                      (req_w.cursor_col == CUR_W'(req_w.cell_col)) &&
                      (req_w.cursor_row == CUR_W'(req_w.cell_row));
   assign a_take    = req_fire && is_render && in_range;

   assign req_tready = !clear_busy && b_free;

   // memories
   tmcr_glyph_store u_glyph (
      .clock   (clock),
      .wr_en   (req_fire && (req_tuser == OP_LOAD)),
      .wr_addr (req_w.glyph_index),
      .wr_data (req_w.glyph_bits),
      .rd_en   (a_take),
      .rd_addr (req_w.char_code),
      .rd_data (glyph_rd)
   );

   tmcr_shown_store #(
      .CELL_COUNT (CellCount),
      .CELL_W     (CellW)
   ) u_shown (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (shown_wr),
      .wr_addr    (b_cell_ff),
      .wr_data    (shown_wr_data),
      .rd_en      (a_take),
      .rd_addr    (a_cell),
      .rd_data    (shown_rd),
      .clear_busy (clear_busy)
   );

   // decide: forwarded pair wins over a stale read of the same cell
   assign eff_valid = fwd_hit_ff || shown_rd.valid;
   assign eff_pair  = fwd_hit_ff ? fwd_pair_ff : shown_rd.pair;
   assign b_draw    = b_force_ff || !eff_valid || (eff_pair != b_pair_ff);
   assign b_go      = b_valid_ff && (!b_draw || emit_free);
   assign b_free    = !b_valid_ff || b_go;
   assign emit_load = b_valid_ff && b_draw && emit_free;
   assign shown_wr  = emit_load;

   assign shown_wr_data.valid = 1'b1;
   assign shown_wr_data.pair  = b_pair_ff;

   // same cell written while the next item reads it
   assign fwd_hit_in = a_take && shown_wr && (b_cell_ff == a_cell);

   // colors, swapped under the cursor
   assign fg_idx = b_cursor_ff ? b_pair_ff[7:4] : b_pair_ff[3:0];
   assign bg_idx = b_cursor_ff ? b_pair_ff[3:0] : b_pair_ff[7:4];

   assign job.col   = b_col_ff;
   assign job.row   = b_row_ff;
   assign job.fg    = palette_color(fg_idx);
   assign job.bg    = palette_color(bg_idx);
   assign job.glyph = glyph_rd;

   // decide stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= a_take;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         b_cell_ff   <= a_cell;
         b_pair_ff   <= {req_w.char_code, req_w.attr_byte};
         b_cursor_ff <= at_cursor;
         b_force_ff  <= req_w.force_redraw || at_cursor;
         b_col_ff    <= req_w.cell_col;
         b_row_ff    <= req_w.cell_row;
         fwd_pair_ff <= b_pair_ff;
      end
   end

   // pixel output
   tmcr_pixel_gen u_pix (
      .clock      (clock),
      .reset      (reset),
      .load_en    (emit_load),
      .load_job   (job),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !clear_busy)
      else $error("request taken during clearing pass");

   a_decide_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_go) |=> (b_valid_ff && $stable(b_cell_ff) && $stable(b_pair_ff)))
      else $error("stalled cell lost its decide stage");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(shown_wr && clear_busy))
      else $error("shown store written during clearing pass");

endmodule

`default_nettype wire

// File: test/text_mode_cell_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_cell_renderer_tb
// Feeds glyph loads and cell renders into the renderer and checks every pixel
// word against a cycle-free model of the cell cache, glyph store and palette.
// Directed cases come first. A long output hold-off follows, then random
// traffic with idle bursts on both sides, and a final stretch with none.
// ----------------------------------------------------------------------------

module text_mode_cell_renderer_tb;
   import tmcr_pkg::*;

   localparam int SCREEN_COLS = TEXT_COLS_DEF;
   localparam int SCREEN_ROWS = TEXT_ROWS_DEF;
   localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
   localparam int HOLD_CYCLES = 600;

   // 16-color palette, entry 0 in the low bits
   localparam logic [16*32-1:0] PALETTE_BITS = {
      32'hFFFFFFFF, 32'hFFFFFF55, 32'hFFFF55FF, 32'hFFFF5555,
      32'hFF55FFFF, 32'hFF55FF55, 32'hFF5555FF, 32'hFF555555,
      32'hFFAAAAAA, 32'hFFAA5500, 32'hFFAA00AA, 32'hFFAA0000,
      32'hFF00AAAA, 32'hFF00AA00, 32'hFF0000AA, 32'hFF000000
   };

   typedef struct packed {
      logic [PIX_X_W-1:0] x;
      logic [PIX_Y_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;

   // model state
   bit [15:0]          shown_pair  [CELL_COUNT];
   bit                 shown_valid [CELL_COUNT];
   logic [GLYPH_W-1:0] glyph_mem   [GLYPH_DEPTH];
   bit                 glyph_written [GLYPH_DEPTH];
   logic [7:0]         written_chars [$];
   pixel_type          pending_pixels [$];

   // run control and tallies
   bit idle_enable;
   int hold_request;
   int mismatch_count = 0;
   int loads_done = 0;
   int cells_drawn = 0;
   int cells_skipped = 0;
   int cells_offscreen = 0;
   int pixels_checked = 0;

   text_mode_cell_renderer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d pixel words still expected",
               pending_pixels.size());
      $display("text_mode_cell_renderer_tb: FAIL");
      $finish;
   end

   // works out the pixel words one accepted word causes
   task automatic predict_item(input logic op_code, input req_word_type w);
      int         cell_idx;
      bit [15:0]  pair;
      bit         at_cursor;
      logic [31:0] fg, bg, tmp;
      logic [63:0] glyph;
      pixel_type  p;
      int         k;
      if (op_code == OP_LOAD) begin
         glyph_mem[w.glyph_index] = w.glyph_bits;
         if (!glyph_written[w.glyph_index]) begin
            glyph_written[w.glyph_index] = 1'b1;
            written_chars.push_back(w.glyph_index);
         end
         loads_done++;
         return;
      end
      if (w.cell_col >= SCREEN_COLS || w.cell_row >= SCREEN_ROWS) begin
         cells_offscreen++;
         return;
      end
      cell_idx = int'(w.cell_row) * SCREEN_COLS + int'(w.cell_col);
      pair = {w.char_code, w.attr_byte};
      at_cursor = w.cursor_shown && w.cursor_col == {1'b0, w.cell_col}
                  && w.cursor_row == {3'b000, w.cell_row};
      if (!w.force_redraw && !at_cursor && shown_valid[cell_idx] &&
          shown_pair[cell_idx] == pair) begin
         cells_skipped++;
         return;
      end
      shown_valid[cell_idx] = 1'b1;
      shown_pair[cell_idx] = pair;
      fg = PALETTE_BITS[w.attr_byte[3:0]*32 +: 32];
      bg = PALETTE_BITS[w.attr_byte[7:4]*32 +: 32];
      if (at_cursor) begin
         tmp = fg;
         fg = bg;
         bg = tmp;
      end
      glyph = glyph_mem[w.char_code];
      k = 0;
      for (int gy = 0; gy < 8; gy++) begin
         for (int gx = 0; gx < 8; gx++) begin
            p.x = {w.cell_col, 3'b000} + PIX_X_W'(gx);
            p.y = {w.cell_row, 3'b000} + PIX_Y_W'(gy);
            p.color = glyph[gy*8 + 7 - gx] ? fg : bg;
            p.last = (k == 63);
            pending_pixels.push_back(p);
            k++;
         end
      end
      cells_drawn++;
   endtask

   // word with every field random, pad cleared
   function automatic req_word_type random_word();
      logic [127:0] r;
      req_word_type w;
      r = {$urandom, $urandom, $urandom, $urandom};
      w = r[REQ_DATA_W-1:0];
      w.pad = '0;
      return w;
   endfunction

   // offers one word from a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input logic op_code, input req_word_type w);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tdata  <= w;
      req_tuser  <= op_code;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_item(op_code, w);
      @(negedge clock);
   endtask

   task automatic load_glyph(input logic [7:0] idx, input logic [63:0] bits);
      req_word_type w;
      w = random_word();
      w.glyph_index = idx;
      w.glyph_bits = bits;
      send_word(OP_LOAD, w);
   endtask

   task automatic render_cell(input int col, input int row, input logic [7:0] ch,
                              input logic [7:0] attr, input bit force_bit,
                              input bit cur_on, input int cur_col, input int cur_row);
      req_word_type w;
      w = random_word();
      w.cell_col = COL_W'(col);
      w.cell_row = ROW_W'(row);
      w.char_code = ch;
      w.attr_byte = attr;
      w.force_redraw = force_bit;
      w.cursor_shown = cur_on;
      w.cursor_col = CUR_W'(cur_col);
      w.cursor_row = CUR_W'(cur_row);
      send_word(OP_RENDER, w);
   endtask

   // one random word, mostly renders of known glyphs, half of them on a few hot cells
   task automatic random_item();
      int         sel;
      int         col, row, cell_idx;
      logic [7:0] ch, attr;
      bit         cur_on;
      int         cc, cr;
      req_word_type w;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         w = random_word();
         if (sel < 2) w.glyph_bits = '0;
         else if (sel < 4) w.glyph_bits = '1;
         send_word(OP_LOAD, w);
         return;
      end
      if (sel < 18) begin
         w = random_word();
         if ($urandom_range(0, 1)) w.cell_col = COL_W'($urandom_range(SCREEN_COLS, 127));
         else w.cell_row = ROW_W'($urandom_range(SCREEN_ROWS, 31));
         w.glyph_index = written_chars[0];
         send_word(OP_RENDER, w);
         return;
      end
      if ($urandom_range(0, 1)) begin
         col = $urandom_range(0, 3);
         row = $urandom_range(0, 2);
      end else begin
         col = $urandom_range(0, SCREEN_COLS - 1);
         row = $urandom_range(0, SCREEN_ROWS - 1);
      end
      cell_idx = row * SCREEN_COLS + col;
      if (shown_valid[cell_idx] && $urandom_range(0, 2) == 0) begin
         // same pair as shown, skipped unless forced or under the cursor
         ch = shown_pair[cell_idx][15:8];
         attr = shown_pair[cell_idx][7:0];
      end else begin
         ch = written_chars[$urandom_range(0, written_chars.size() - 1)];
         attr = 8'($urandom);
      end
      cur_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         cc = col;
         cr = row;
      end else begin
         cc = $urandom_range(0, 255);
         cr = $urandom_range(0, 255);
      end
      render_cell(col, row, ch, attr, $urandom_range(0, 9) == 0, cur_on, cc, cr);
   endtask

   // glyph store extremes and a few patterns
   task automatic test_directed_glyphs();
      load_glyph(8'h00, 64'h0000000000000000);
      load_glyph(8'hFF, 64'hFFFFFFFFFFFFFFFF);
      load_glyph(8'h41, 64'h0123456789ABCDEF);
      load_glyph(8'h55, 64'h55AA55AA55AA55AA);
      load_glyph(8'hAA, 64'h8142241818244281);
   endtask

   // redraw rules, cursor swap, screen corners and off-screen cells
   task automatic test_directed_cells();
      render_cell(0, 0, 8'h41, 8'h07, 0, 0, 0, 0);
      render_cell(0, 0, 8'h41, 8'h07, 0, 0, 0, 0);
      render_cell(0, 0, 8'h41, 8'h07, 1, 0, 0, 0);
      render_cell(0, 0, 8'h41, 8'h70, 0, 0, 0, 0);
      render_cell(79, 24, 8'hFF, 8'hF0, 0, 0, 0, 0);
      render_cell(79, 24, 8'hFF, 8'hF0, 0, 1, 79, 24);
      render_cell(79, 24, 8'hFF, 8'hF0, 0, 0, 79, 24);
      render_cell(79, 24, 8'hFF, 8'hF0, 0, 1, 79, 23);
      render_cell(80, 0, 8'h41, 8'h1E, 1, 0, 80, 0);
      render_cell(127, 31, 8'h41, 8'h1E, 1, 1, 127, 31);
      render_cell(0, 25, 8'h41, 8'h1E, 1, 1, 0, 25);
      render_cell(10, 5, 8'h00, 8'h0F, 0, 1, 255, 255);
      render_cell(10, 5, 8'h55, 8'hFF, 0, 0, 10, 5);
      render_cell(10, 5, 8'hAA, 8'h00, 0, 1, 10, 5);
   endtask

   // output held off while forced cells keep coming, so input backs up
   task automatic test_input_backpressure();
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 8; i++) begin
         render_cell($urandom_range(0, SCREEN_COLS - 1), $urandom_range(0, SCREEN_ROWS - 1),
                     written_chars[$urandom_range(0, written_chars.size() - 1)],
                     8'($urandom), 1, 0, 0, 0);
      end
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) random_item();
   endtask

   task automatic test_back_to_back(input int count);
      idle_enable = 1'b0;
      for (int i = 0; i < count; i++) random_item();
   endtask

   // rsp_tready: random stall bursts plus the long hold-off on request
   initial begin : rsp_ready_gen
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each accepted pixel word with the oldest expected one
   always @(posedge clock) begin : check_pixels
      rsp_word_type got;
      pixel_type    exp_pix;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected pixel word: x=%0d y=%0d color=%08h last=%b",
                        got.pixel_x, got.pixel_y, got.pixel_color, rsp_tlast);
         end else begin
            exp_pix = pending_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_x !== exp_pix.x || got.pixel_y !== exp_pix.y ||
                got.pixel_color !== exp_pix.color || rsp_tlast !== exp_pix.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"pixel %0d: expected x=%0d y=%0d color=%08h last=%b, ",
                            "got x=%0d y=%0d color=%08h last=%b"},
                           pixels_checked, exp_pix.x, exp_pix.y, exp_pix.color,
                           exp_pix.last, got.pixel_x, got.pixel_y, got.pixel_color,
                           rsp_tlast);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = OP_LOAD;
      req_tdata = '0;
      idle_enable = 1'b1;
      hold_request = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_glyphs();
      test_directed_cells();
      test_input_backpressure();
      test_random_traffic(400);
      test_back_to_back(60);
      req_tvalid <= 1'b0;

      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display({"covered %0d glyph loads, %0d drawn cells (%0d pixels), ",
                "%0d skipped and %0d off-screen renders"},
               loads_done, cells_drawn, pixels_checked, cells_skipped, cells_offscreen);
      $display({"with a %0d-cycle output hold-off, random idle bursts and a final ",
                "burst-free stretch; %0d mismatches"},
               HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("text_mode_cell_renderer_tb: PASS");
      end else begin
         $display("text_mode_cell_renderer_tb: FAIL");
      end
      $finish;
   end

endmodule
